[rtl/core/twst_pkg.sv]
// twst_pkg: shared types, constants and register indexes for the
// twist-to-skid-steer PWM mixer. No dependencies.
package twst_pkg;

  localparam int DUTY_BITS   = 10;
  localparam int DUTY_MAX    = (1 << DUTY_BITS) - 1;
  localparam int Q_SHIFT     = 12;
  localparam int Q_ONE       = 1 << Q_SHIFT;
  localparam int MAG_W       = Q_SHIFT + 1;
  localparam int CFG_DUTY_W  = 10;
  localparam int CFG_DB_W    = 13;
  localparam int CFG_TO_W    = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int VEL_W       = 16;
  localparam int TICK_W      = 16;
  // floor(x / 5) == (x * DIV5_RECIP) >> DIV5_SHIFT for x below 16384
  localparam int DIV5_RECIP  = 13108;
  localparam int DIV5_SHIFT  = 16;

  localparam logic [CFG_DUTY_W-1:0] RST_MIN_DUTY = CFG_DUTY_W'(250);
  localparam logic [CFG_DUTY_W-1:0] RST_MAX_DUTY = CFG_DUTY_W'(400);
  localparam logic [CFG_DB_W-1:0]   RST_LIN_DB   = CFG_DB_W'(82);
  localparam logic [CFG_DB_W-1:0]   RST_ANG_DB   = CFG_DB_W'(82);
  localparam logic [CFG_TO_W-1:0]   RST_TIMEOUT  = CFG_TO_W'(2000);

  localparam logic MODE_CMD  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_DUTY = 3'd0,
    CFG_MAX_DUTY = 3'd1,
    CFG_LIN_DB   = 3'd2,
    CFG_ANG_DB   = 3'd3,
    CFG_TIMEOUT  = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_DRIVING = 2'd0,
    ST_NO_CMD  = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_t;

  typedef struct packed {
    logic [CFG_DUTY_W-1:0] min_duty;
    logic [CFG_DUTY_W-1:0] max_duty;
    logic [CFG_DB_W-1:0]   lin_db;
    logic [CFG_DB_W-1:0]   ang_db;
    logic [CFG_TO_W-1:0]   timeout;
  } cfg_t;

  typedef struct packed {
    status_t          status;
    logic             fwd_nz;
    logic             fwd_neg;
    logic [MAG_W-1:0] fwd_mag;
    logic             turn_nz;
    logic             turn_neg;
    logic [MAG_W-1:0] turn_mag;
  } front_t;

  typedef struct packed {
    status_t              status;
    logic                 fwd_nz;
    logic                 fwd_neg;
    logic                 turn_nz;
    logic                 turn_neg;
    logic [DUTY_BITS-1:0] base;
    logic [DUTY_BITS-1:0] tduty;
  } duty_t;

  typedef struct packed {
    status_t              status;
    logic [DUTY_BITS-1:0] right_rev;
    logic [DUTY_BITS-1:0] right_fwd;
    logic [DUTY_BITS-1:0] left_rev;
    logic [DUTY_BITS-1:0] left_fwd;
  } mix_t;

endpackage

[rtl/core/twst_front.sv]
// twst_front: held command, elapsed-tick counter, timeout check and
// deadbands; registers the result as stage one. Depends on twst_pkg.
module twst_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic                        mode,
  input  logic [twst_pkg::VEL_W-1:0]  lin_x,
  input  logic [twst_pkg::VEL_W-1:0]  lin_y,
  input  logic [twst_pkg::VEL_W-1:0]  ang_z,
  input  twst_pkg::cfg_t              cfg,
  output twst_pkg::front_t            front
);
  import twst_pkg::*;

  logic [VEL_W-1:0]  held_lin_x, held_lin_y, held_ang_z;
  logic [VEL_W-1:0]  held_lin_x_next, held_lin_y_next, held_ang_z_next;
  logic              have_command, have_command_next;
  logic [TICK_W-1:0] elapsed_ticks, elapsed_ticks_next;
  logic [VEL_W-1:0]  fwd_raw;
  logic [VEL_W:0]    fwd_abs, turn_abs;
  front_t            front_next;

  function automatic logic [VEL_W:0] abs_ext(input logic [VEL_W-1:0] v);
    logic signed [VEL_W:0] e;
    e = $signed({v[VEL_W-1], v});
    return e[VEL_W] ? unsigned'(-e) : unsigned'(e);
  endfunction

  function automatic logic [MAG_W-1:0] sat_mag(input logic [VEL_W:0] a);
    return (a > (VEL_W+1)'(Q_ONE)) ? MAG_W'(Q_ONE) : a[MAG_W-1:0];
  endfunction

  always_comb begin
    held_lin_x_next    = held_lin_x;
    held_lin_y_next    = held_lin_y;
    held_ang_z_next    = held_ang_z;
    have_command_next  = have_command;
    elapsed_ticks_next = elapsed_ticks;
    if (mode == MODE_CMD) begin
      held_lin_x_next    = lin_x;
      held_lin_y_next    = lin_y;
      held_ang_z_next    = ang_z;
      have_command_next  = 1'b1;
      elapsed_ticks_next = '0;
    end else if (elapsed_ticks != '1) begin
      elapsed_ticks_next = elapsed_ticks + TICK_W'(1);
    end
  end

  always_comb begin
    fwd_raw  = (held_lin_y_next != '0) ? held_lin_y_next : held_lin_x_next;
    fwd_abs  = abs_ext(fwd_raw);
    turn_abs = abs_ext(held_ang_z_next);
    priority if (!have_command_next) begin
      front_next.status = ST_NO_CMD;
    end else if (elapsed_ticks_next > cfg.timeout) begin
      front_next.status = ST_TIMEOUT;
    end else begin
      front_next.status = ST_DRIVING;
    end
    front_next.fwd_nz   = (fwd_abs != '0) && (fwd_abs >= (VEL_W+1)'(cfg.lin_db));
    front_next.fwd_neg  = fwd_raw[VEL_W-1];
    front_next.fwd_mag  = sat_mag(fwd_abs);
    front_next.turn_nz  = (turn_abs != '0) && (turn_abs >= (VEL_W+1)'(cfg.ang_db));
    front_next.turn_neg = held_ang_z_next[VEL_W-1];
    front_next.turn_mag = sat_mag(turn_abs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_lin_x    <= '0;
      held_lin_y    <= '0;
      held_ang_z    <= '0;
      have_command  <= 1'b0;
      elapsed_ticks <= '0;
    end else if (accept) begin
      held_lin_x    <= held_lin_x_next;
      held_lin_y    <= held_lin_y_next;
      held_ang_z    <= held_ang_z_next;
      have_command  <= have_command_next;
      elapsed_ticks <= elapsed_ticks_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front <= front_next;
    end
  end

endmodule

[rtl/core/twst_duty.sv]
// twst_duty: maps forward and turn magnitudes to duties (one multiply
// each) and registers stage two. Depends on twst_pkg.
module twst_duty (
  input  logic              clk,
  input  logic              load,
  input  twst_pkg::front_t  front,
  input  twst_pkg::cfg_t    cfg,
  output twst_pkg::duty_t   duty
);
  import twst_pkg::*;

  duty_t duty_next;

  function automatic logic [DUTY_BITS-1:0] to_duty(
    input logic                  nz,
    input logic [MAG_W-1:0]      mag,
    input logic [CFG_DUTY_W-1:0] dmin,
    input logic [CFG_DUTY_W-1:0] dmax
  );
    logic signed [CFG_DUTY_W:0]       span;
    logic signed [MAG_W+CFG_DUTY_W:0] prod;
    logic signed [MAG_W+CFG_DUTY_W:0] prod_neg;
    logic signed [MAG_W-1:0]          q;
    logic signed [MAG_W:0]            v;
    span     = $signed({1'b0, dmax}) - $signed({1'b0, dmin});
    prod     = $signed({1'b0, mag}) * span;
    prod_neg = -prod;
    // quotient truncates toward zero
    q = prod[MAG_W+CFG_DUTY_W] ? -$signed(MAG_W'(prod_neg >>> Q_SHIFT))
                               : $signed(MAG_W'(prod >>> Q_SHIFT));
    v = $signed({(MAG_W+1-CFG_DUTY_W)'(0), dmin}) + $signed({q[MAG_W-1], q});
    if (!nz) return '0;
    if (v < 0) return '0;
    if (v > (MAG_W+1)'(DUTY_MAX)) return DUTY_BITS'(DUTY_MAX);
    return DUTY_BITS'(v);
  endfunction

  always_comb begin
    duty_next.status   = front.status;
    duty_next.fwd_nz   = front.fwd_nz;
    duty_next.fwd_neg  = front.fwd_neg;
    duty_next.turn_nz  = front.turn_nz;
    duty_next.turn_neg = front.turn_neg;
    duty_next.base     = to_duty(front.fwd_nz, front.fwd_mag, cfg.min_duty, cfg.max_duty);
    duty_next.tduty    = to_duty(front.turn_nz, front.turn_mag, cfg.min_duty,
                                 cfg.max_duty);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      duty <= duty_next;
    end
  end

endmodule

[rtl/core/twst_mix.sv]
// twst_mix: picks stop, spin, straight or arc and builds the four channel
// duties into the output register. Depends on twst_pkg.
module twst_mix (
  input  logic             clk,
  input  logic             load,
  input  twst_pkg::duty_t  duty,
  output twst_pkg::mix_t   mix
);
  import twst_pkg::*;

  localparam int PROD_W = DUTY_BITS + 2 + DIV5_SHIFT;

  logic [DUTY_BITS+1:0] t3;
  logic [PROD_W-1:0]    t3_scaled;
  logic [DUTY_BITS-1:0] delta;
  logic [DUTY_BITS:0]   outer_sum;
  logic [DUTY_BITS-1:0] inner, outer;
  logic [DUTY_BITS-1:0] left_spd, right_spd;
  logic                 left_fwd_dir, right_fwd_dir;
  mix_t                 mix_next;

  always_comb begin
    t3        = (DUTY_BITS+2)'(duty.tduty) * (DUTY_BITS+2)'(3);
    t3_scaled = PROD_W'(t3) * PROD_W'(DIV5_RECIP);
    delta     = DUTY_BITS'(t3_scaled >> DIV5_SHIFT);
    inner     = (duty.base > delta) ? duty.base - delta : '0;
    outer_sum = {1'b0, duty.base} + {1'b0, delta};
    outer     = outer_sum[DUTY_BITS] ? DUTY_BITS'(DUTY_MAX) : outer_sum[DUTY_BITS-1:0];
  end

  always_comb begin
    left_spd      = '0;
    right_spd     = '0;
    left_fwd_dir  = 1'b1;
    right_fwd_dir = 1'b1;
    if (duty.status == ST_DRIVING) begin
      priority if (!duty.fwd_nz && !duty.turn_nz) begin
        left_spd  = '0;
        right_spd = '0;
      end else if (!duty.fwd_nz) begin
        left_spd      = duty.tduty;
        right_spd     = duty.tduty;
        left_fwd_dir  = duty.turn_neg;
        right_fwd_dir = !duty.turn_neg;
      end else if (!duty.turn_nz) begin
        left_spd      = duty.base;
        right_spd     = duty.base;
        left_fwd_dir  = !duty.fwd_neg;
        right_fwd_dir = !duty.fwd_neg;
      end else begin
        // left is the inner side on a left turn
        left_spd      = duty.turn_neg ? outer : inner;
        right_spd     = duty.turn_neg ? inner : outer;
        left_fwd_dir  = !duty.fwd_neg;
        right_fwd_dir = !duty.fwd_neg;
      end
    end
    mix_next.status    = duty.status;
    mix_next.left_fwd  = left_fwd_dir ? left_spd : '0;
    mix_next.left_rev  = left_fwd_dir ? '0 : left_spd;
    mix_next.right_fwd = right_fwd_dir ? right_spd : '0;
    mix_next.right_rev = right_fwd_dir ? '0 : right_spd;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mix <= mix_next;
    end
  end

endmodule

[rtl/core/twist_to_skid_steer_pwm.sv]
// twist_to_skid_steer_pwm: top level of the skid-steer PWM mixer.
// Depends on twst_pkg, twst_front, twst_duty, twst_mix.
//
// Usage:
//   Slave stream s_*: one beat is a velocity command (tuser = 0) carrying
//   lin_x, lin_y, ang_z in signed Q3.12, or a 1 ms tick (tuser = 1).
//   Master stream m_*: exactly one beat per input beat, in order, with the
//   four channel duties and a status code (0 driving, 1 no command yet,
//   2 timed out).
//   Config port: cfg_we writes cfg_data into register cfg_index at the
//   clock edge; write only while no beats are in flight.
// Timing:
//   Three register stages (state/deadband, duty multiply, mix/output).
//   One beat per cycle sustained while m_tready is high. Stages shift
//   only where the next one is free, so a stall on m_tready fills the
//   empty stages before s_tready drops.
// Reset:
//   rst (synchronous) empties the pipe, clears the held command and tick
//   count, and loads the register defaults (250, 400, 82, 82, 2000).
module twist_to_skid_steer_pwm (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [47:0]                        s_tdata,  // lin_x, lin_y, ang_z
  input  logic                               s_tuser,  // mode
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // left_fwd_duty, left_rev_duty, right_fwd_duty, right_rev_duty, status, zero pad
  output logic [47:0]                        m_tdata,
  input  logic                               cfg_we,
  input  logic [twst_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [twst_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import twst_pkg::*;

  localparam int OUT_W = 4 * DUTY_BITS + 2;

  cfg_t   cfg;
  front_t front;
  duty_t  duty;
  mix_t   mix;
  logic   v1, v2, v3;
  logic   adv1, adv2, adv3;
  logic   accept;

  assign adv3     = !v3 || m_tready;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign s_tready = adv1;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_duty <= RST_MIN_DUTY;
      cfg.max_duty <= RST_MAX_DUTY;
      cfg.lin_db   <= RST_LIN_DB;
      cfg.ang_db   <= RST_ANG_DB;
      cfg.timeout  <= RST_TIMEOUT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_DUTY: cfg.min_duty <= cfg_data[CFG_DUTY_W-1:0];
        CFG_MAX_DUTY: cfg.max_duty <= cfg_data[CFG_DUTY_W-1:0];
        CFG_LIN_DB:   cfg.lin_db   <= cfg_data[CFG_DB_W-1:0];
        CFG_ANG_DB:   cfg.ang_db   <= cfg_data[CFG_DB_W-1:0];
        CFG_TIMEOUT:  cfg.timeout  <= cfg_data[CFG_TO_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= accept;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  twst_front u_front (
    .clk   (clk),
    .rst   (rst),
    .accept(accept),
    .mode  (s_tuser),
    .lin_x (s_tdata[15:0]),
    .lin_y (s_tdata[31:16]),
    .ang_z (s_tdata[47:32]),
    .cfg   (cfg),
    .front (front)
  );

  twst_duty u_duty (
    .clk  (clk),
    .load (v1 && adv2),
    .front(front),
    .cfg  (cfg),
    .duty (duty)
  );

  twst_mix u_mix (
    .clk (clk),
    .load(v2 && adv3),
    .duty(duty),
    .mix (mix)
  );

  assign m_tvalid = v3;
  assign m_tdata  = {(48 - OUT_W)'(0), mix.status, mix.right_rev, mix.right_fwd,
                     mix.left_rev, mix.left_fwd};

  a_stopped_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && mix.status != ST_DRIVING) |->
      (mix.left_fwd == '0 && mix.left_rev == '0 &&
       mix.right_fwd == '0 && mix.right_rev == '0))
    else $error("duty nonzero while stopped");

  a_one_dir: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((mix.left_fwd == '0 || mix.left_rev == '0) &&
                  (mix.right_fwd == '0 || mix.right_rev == '0)))
    else $error("both channels of one side driven");

  a_cmd_drives: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == MODE_CMD) |=> (front.status == ST_DRIVING))
    else $error("command did not restart driving");

  a_stage_move: assert property (@(posedge clk) disable iff (rst)
    (v2 && adv3) |=> v3)
    else $error("stage two beat lost");

endmodule
